### src/srsp_pkg.sv
// Shared types, codes and BCD helper for the serial RTC system port.
`default_nettype none
package srsp_pkg;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_TICK  = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    PORT_RTC_CTRL = 3'd0,
    PORT_RTC_MODE = 3'd1,
    PORT_IRQ_MODE = 3'd2,
    PORT_A        = 3'd3,
    PORT_B        = 3'd4,
    PORT_C        = 3'd5,
    PORT_SYS_CTRL = 3'd6,
    PORT_UNUSED   = 3'd7
  } port_t;

  localparam logic [2:0] CMD_READ = 3'd3;
  localparam logic [2:0] CMD_EXT  = 3'd7;
  localparam logic [1:0] IRQ_OFF  = 2'd2;
  localparam logic [7:0] RD_IDLE  = 8'hff;
  localparam logic [7:0] PORT_A_FIXED = 8'h73;
  localparam logic [4:0] PORT_B_HIGH  = 5'h1f;
  localparam logic [6:0] CENTURY = 7'd100;

  typedef struct packed {
    logic [1:0] op;
    logic [2:0] port;
    logic [7:0] write_data;
    logic [5:0] now_sec;
    logic [5:0] now_min;
    logic [4:0] now_hour;
    logic [4:0] now_mday;
    logic [2:0] now_wday;
    logic [3:0] now_month;
    logic [6:0] now_year;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq_level;
    logic [7:0] port_c_out;
    logic       shutdown_flag;
  } result_t;

  function automatic logic [7:0] bcd8(input logic [6:0] v);
    logic [17:0] prod;
    logic [3:0]  tens;
    logic [6:0]  units;
    prod  = 18'(v) * 18'd205;
    tens  = prod[14:11];
    units = v - 7'(tens) * 7'd10;
    return {tens, units[3:0]};
  endfunction

endpackage
`default_nettype wire

### src/srsp_time_pack.sv
// Packs the binary time inputs into the 52-bit BCD shift image.
`default_nettype none
module srsp_time_pack import srsp_pkg::*; (
  input  item_t       item,
  input  logic        wide,
  output logic [51:0] image
);

  logic [6:0]  yr;
  logic [3:0]  mon;
  logic [47:0] t48;

  assign yr  = (item.now_year >= CENTURY) ? item.now_year - CENTURY : item.now_year;
  assign mon = item.now_month + 4'd1;
  assign t48 = {bcd8(yr), mon, 1'b0, item.now_wday,
                bcd8({2'b00, item.now_mday}), bcd8({2'b00, item.now_hour}),
                bcd8({1'b0, item.now_min}), bcd8({1'b0, item.now_sec})};
  assign image = wide ? {t48, 4'b0000} : {4'b0000, t48};

endmodule
`default_nettype wire

### src/srsp_core.sv
// Port state registers and the per-item read/write/tick update.
`default_nettype none
module srsp_core import srsp_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    adv,
  input  item_t   item,
  output result_t res
);

  logic [7:0]  rtc_mode_r, rtc_mode_nxt;
  logic [7:0]  ctrl_last_r, ctrl_last_nxt;
  logic [51:0] time_shift_r, time_shift_nxt;
  logic [3:0]  cmd_shift_r, cmd_shift_nxt;
  logic [7:0]  irq_mode_r, irq_mode_nxt;
  logic [2:0]  tick_r, tick_nxt;
  logic        irq_r, irq_nxt;
  logic [7:0]  port_a_r, port_a_nxt;
  logic [7:0]  port_c_r, port_c_nxt;
  logic [7:0]  sys_mode_r, sys_mode_nxt;

  logic [51:0] image;
  logic [7:0]  rd;
  logic [7:0]  wd;
  logic [3:0]  cmd_sel;
  logic [2:0]  tick_inc;
  logic [51:0] ts_tmp;

  srsp_time_pack u_pack (
    .item  (item),
    .wide  (rtc_mode_r[5]),
    .image (image)
  );

  assign wd       = item.write_data;
  assign tick_inc = tick_r + 3'd1;
  assign cmd_sel  = (ctrl_last_r[2:0] == CMD_EXT) ? cmd_shift_r : {1'b0, ctrl_last_r[2:0]};

  always_comb begin
    rtc_mode_nxt   = rtc_mode_r;
    ctrl_last_nxt  = ctrl_last_r;
    time_shift_nxt = time_shift_r;
    cmd_shift_nxt  = cmd_shift_r;
    irq_mode_nxt   = irq_mode_r;
    tick_nxt       = tick_r;
    irq_nxt        = irq_r;
    port_a_nxt     = port_a_r;
    port_c_nxt     = port_c_r;
    sys_mode_nxt   = sys_mode_r;
    rd             = RD_IDLE;
    ts_tmp         = time_shift_r;
    unique case (item.op)
      OP_READ: begin
        unique case (item.port)
          PORT_RTC_MODE: rd = rtc_mode_r;
          PORT_IRQ_MODE: begin
            irq_nxt = 1'b0;
            rd      = irq_mode_r;
          end
          PORT_A: rd = sys_mode_r[4] ? PORT_A_FIXED : port_a_r;
          PORT_B: rd = sys_mode_r[1] ? {PORT_B_HIGH, 2'b00, time_shift_r[0]} : port_a_r;
          PORT_C: rd = port_c_r;
          default: rd = RD_IDLE;
        endcase
      end
      OP_WRITE: begin
        unique case (item.port)
          PORT_RTC_CTRL: begin
            if (ctrl_last_r[3] && !wd[3] && cmd_sel == {1'b0, CMD_READ}) begin
              ts_tmp = image;
            end
            if (ctrl_last_r[4] && !wd[4]) begin
              cmd_shift_nxt = {ctrl_last_r[5], cmd_shift_r[3:1]};
              ts_tmp        = {1'b0, ts_tmp[51:1]};
            end
            time_shift_nxt = ts_tmp;
            ctrl_last_nxt  = wd;
          end
          PORT_RTC_MODE: rtc_mode_nxt = wd;
          PORT_IRQ_MODE: begin
            irq_mode_nxt = wd;
            tick_nxt     = 3'd0;
          end
          PORT_A: port_a_nxt = wd;
          PORT_C: port_c_nxt = wd;
          PORT_SYS_CTRL: begin
            if (!wd[7]) begin
              port_c_nxt[wd[3:1]] = wd[0];
            end else begin
              sys_mode_nxt = wd;
            end
          end
          default: ;
        endcase
      end
      OP_TICK: begin
        if (irq_mode_r[1:0] != IRQ_OFF) begin
          if (tick_inc > {1'b0, irq_mode_r[1:0]}) begin
            irq_nxt  = 1'b1;
            tick_nxt = 3'd0;
          end else begin
            tick_nxt = tick_inc;
          end
        end
      end
      default: ;
    endcase
  end

  assign res.read_data     = rd;
  assign res.irq_level     = irq_nxt;
  assign res.port_c_out    = port_c_nxt;
  assign res.shutdown_flag = port_c_nxt[7] & port_c_nxt[5];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rtc_mode_r   <= 8'hff;
      ctrl_last_r  <= 8'h00;
      time_shift_r <= '0;
      cmd_shift_r  <= 4'h0;
      irq_mode_r   <= 8'h02;
      tick_r       <= 3'd0;
      irq_r        <= 1'b0;
      port_a_r     <= 8'h00;
      port_c_r     <= 8'hff;
      sys_mode_r   <= 8'h92;
    end else if (adv) begin
      rtc_mode_r   <= rtc_mode_nxt;
      ctrl_last_r  <= ctrl_last_nxt;
      time_shift_r <= time_shift_nxt;
      cmd_shift_r  <= cmd_shift_nxt;
      irq_mode_r   <= irq_mode_nxt;
      tick_r       <= tick_nxt;
      irq_r        <= irq_nxt;
      port_a_r     <= port_a_nxt;
      port_c_r     <= port_c_nxt;
      sys_mode_r   <= sys_mode_nxt;
    end
  end

endmodule
`default_nettype wire

### src/serial_rtc_system_port_top.sv
// Top level: input register, port logic and result register.
//
//   channel | direction | payload
//   in_     | to block  | op, port, write_data, now_* time fields
//   out_    | from block| read_data, irq_level, port_c_out, shutdown_flag
//
// One item per cycle while the output is not stalled.
// The input register feeds the port logic, whose result lands in the output register.
// rst_n is synchronous and clears control and port state.
// A stalled result holds; the input register keeps taking items while it can drain.
`default_nettype none
module serial_rtc_system_port_top import srsp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_op,
  input  logic [2:0] in_port,
  input  logic [7:0] in_write_data,
  input  logic [5:0] in_now_sec,
  input  logic [5:0] in_now_min,
  input  logic [4:0] in_now_hour,
  input  logic [4:0] in_now_mday,
  input  logic [2:0] in_now_wday,
  input  logic [3:0] in_now_month,
  input  logic [6:0] in_now_year,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_read_data,
  output logic       out_irq_level,
  output logic [7:0] out_port_c_out,
  output logic       out_shutdown_flag
);

  item_t   item_r;
  logic    item_v_r;
  result_t res_r;
  logic    out_valid_r;
  result_t res;
  logic    adv;
  logic    in_fire;

  assign adv      = item_v_r && (!out_valid_r || !out_stall);
  assign in_stall = item_v_r && !adv;
  assign in_fire  = in_valid && !in_stall;

  srsp_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .item  (item_r),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        item_v_r <= 1'b1;
      end else if (adv) begin
        item_v_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r <= {in_op, in_port, in_write_data, in_now_sec, in_now_min, in_now_hour,
                 in_now_mday, in_now_wday, in_now_month, in_now_year};
    end
    if (adv) begin
      res_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_read_data     = res_r.read_data;
  assign out_irq_level     = res_r.irq_level;
  assign out_port_c_out    = res_r.port_c_out;
  assign out_shutdown_flag = res_r.shutdown_flag;

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    !item_v_r |-> !in_stall) else $error("input stalled with empty input register");

  a_blocked_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (item_v_r && out_valid_r && out_stall) |-> in_stall)
    else $error("input taken while result blocked");

  a_adv_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_valid_r) else $error("advanced item produced no result");

  a_shutdown_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_shutdown_flag == (out_port_c_out[7] && out_port_c_out[5])))
    else $error("shutdown flag disagrees with port C");

endmodule
`default_nettype wire

### tb/serial_rtc_system_port_top_tb.sv
// Self-checking bench for the serial RTC system port: directed table, then random bus traffic.
module serial_rtc_system_port_top_tb;
  import srsp_pkg::*;

  localparam int N_DIR = 26;
  localparam int N_RANDOM = 1500;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    op_t        op;
    port_t      port;
    logic [7:0] wd;
    logic       tmax;
    logic       typed;
    result_t    res;
  } row_t;

  localparam result_t R_NONE = '0;
  localparam result_t R_IDLE = '{8'hff, 1'b0, 8'hff, 1'b1};

  localparam row_t DIR_TAB [N_DIR] = '{
    '{OP_READ,  PORT_RTC_MODE, 8'h00, 1'b0, 1'b1, R_IDLE},
    '{OP_READ,  PORT_IRQ_MODE, 8'h00, 1'b0, 1'b1, '{8'h02, 1'b0, 8'hff, 1'b1}},
    '{OP_READ,  PORT_A,        8'h00, 1'b0, 1'b1, '{8'h73, 1'b0, 8'hff, 1'b1}},
    '{OP_READ,  PORT_B,        8'h00, 1'b0, 1'b1, '{8'hf8, 1'b0, 8'hff, 1'b1}},
    '{OP_READ,  PORT_RTC_CTRL, 8'h00, 1'b0, 1'b1, R_IDLE},
    '{OP_READ,  PORT_UNUSED,   8'h00, 1'b0, 1'b1, R_IDLE},
    '{OP_NOP,   PORT_UNUSED,   8'hff, 1'b1, 1'b1, R_IDLE},
    '{OP_WRITE, PORT_B,        8'h00, 1'b0, 1'b1, R_IDLE},
    '{OP_WRITE, PORT_UNUSED,   8'hff, 1'b0, 1'b1, R_IDLE},
    '{OP_WRITE, PORT_SYS_CTRL, 8'h0e, 1'b0, 1'b1, '{8'hff, 1'b0, 8'h7f, 1'b0}},
    '{OP_WRITE, PORT_SYS_CTRL, 8'h0f, 1'b0, 1'b1, R_IDLE},
    '{OP_WRITE, PORT_C,        8'h00, 1'b0, 1'b1, '{8'hff, 1'b0, 8'h00, 1'b0}},
    '{OP_READ,  PORT_C,        8'h00, 1'b0, 1'b1, '{8'h00, 1'b0, 8'h00, 1'b0}},
    '{OP_WRITE, PORT_C,        8'ha0, 1'b0, 1'b1, '{8'hff, 1'b0, 8'ha0, 1'b1}},
    '{OP_WRITE, PORT_A,        8'hff, 1'b0, 1'b0, R_NONE},
    '{OP_WRITE, PORT_SYS_CTRL, 8'h80, 1'b0, 1'b0, R_NONE},
    '{OP_READ,  PORT_A,        8'h00, 1'b0, 1'b0, R_NONE},
    '{OP_READ,  PORT_B,        8'h00, 1'b0, 1'b0, R_NONE},
    '{OP_WRITE, PORT_SYS_CTRL, 8'h92, 1'b0, 1'b0, R_NONE},
    '{OP_WRITE, PORT_RTC_MODE, 8'h20, 1'b0, 1'b0, R_NONE},
    '{OP_WRITE, PORT_RTC_CTRL, 8'h1b, 1'b0, 1'b0, R_NONE},
    '{OP_WRITE, PORT_RTC_CTRL, 8'h00, 1'b1, 1'b0, R_NONE},
    '{OP_READ,  PORT_B,        8'h00, 1'b0, 1'b0, R_NONE},
    '{OP_WRITE, PORT_IRQ_MODE, 8'h00, 1'b0, 1'b0, R_NONE},
    '{OP_TICK,  PORT_UNUSED,   8'h00, 1'b0, 1'b0, R_NONE},
    '{OP_READ,  PORT_IRQ_MODE, 8'h00, 1'b0, 1'b0, R_NONE}
  };

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic [1:0] in_op = '0;
  logic [2:0] in_port = '0;
  logic [7:0] in_write_data = '0;
  logic [5:0] in_now_sec = '0;
  logic [5:0] in_now_min = '0;
  logic [4:0] in_now_hour = '0;
  logic [4:0] in_now_mday = '0;
  logic [2:0] in_now_wday = '0;
  logic [3:0] in_now_month = '0;
  logic [6:0] in_now_year = '0;
  logic       out_stall = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic [7:0] out_read_data;
  logic       out_irq_level;
  logic [7:0] out_port_c_out;
  logic       out_shutdown_flag;

  logic [7:0]  m_rtc_mode;
  logic [7:0]  m_ctrl_last;
  logic [3:0]  m_cmd;
  logic [51:0] m_time;
  logic [3:0]  m_cmd_sh;
  logic [7:0]  m_irq_mode;
  logic [2:0]  m_ticks;
  logic        m_irq;
  logic [7:0]  m_port_a;
  logic [7:0]  m_port_c;
  logic [7:0]  m_sys_mode;

  result_t due_q[$];
  int      n_sent = 0;
  int      n_bad = 0;
  int      n_cycles = 0;
  int      hold_n = 0;
  bit      quiet = 1'b0;
  bit      in_calm = 1'b0;
  bit      out_calm = 1'b0;

  serial_rtc_system_port_top u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_op             (in_op),
    .in_port           (in_port),
    .in_write_data     (in_write_data),
    .in_now_sec        (in_now_sec),
    .in_now_min        (in_now_min),
    .in_now_hour       (in_now_hour),
    .in_now_mday       (in_now_mday),
    .in_now_wday       (in_now_wday),
    .in_now_month      (in_now_month),
    .in_now_year       (in_now_year),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_read_data     (out_read_data),
    .out_irq_level     (out_irq_level),
    .out_port_c_out    (out_port_c_out),
    .out_shutdown_flag (out_shutdown_flag)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [7:0] dec2bcd(input logic [6:0] v);
    return {4'((v / 10) % 16), 4'(v % 10)};
  endfunction

  function automatic logic [51:0] packed_time(input item_t it);
    logic [6:0]  yr;
    logic [51:0] t;
    yr = it.now_year;
    if (yr >= CENTURY) yr = yr - CENTURY;
    t = '0;
    t[7:0]   = dec2bcd({1'b0, it.now_sec});
    t[15:8]  = dec2bcd({1'b0, it.now_min});
    t[23:16] = dec2bcd({2'b00, it.now_hour});
    t[31:24] = dec2bcd({2'b00, it.now_mday});
    t[34:32] = it.now_wday;
    t[39:36] = it.now_month + 4'd1;
    t[47:40] = dec2bcd(yr);
    if (m_rtc_mode[5]) t = t << 4;
    return t;
  endfunction

  function automatic result_t step_ports(input item_t it);
    logic [7:0] rd;
    logic [7:0] wd;
    result_t r;
    rd = RD_IDLE;
    wd = it.write_data;
    case (op_t'(it.op))
      OP_READ: begin
        case (port_t'(it.port))
          PORT_RTC_MODE: rd = m_rtc_mode;
          PORT_IRQ_MODE: begin
            m_irq = 1'b0;
            rd = m_irq_mode;
          end
          PORT_A: rd = m_sys_mode[4] ? PORT_A_FIXED : m_port_a;
          PORT_B: rd = m_sys_mode[1] ? {PORT_B_HIGH, 2'b00, m_time[0]} : m_port_a;
          PORT_C: rd = m_port_c;
          default: rd = RD_IDLE;
        endcase
      end
      OP_WRITE: begin
        case (port_t'(it.port))
          PORT_RTC_CTRL: begin
            if (m_ctrl_last[3] && !wd[3]) begin
              m_cmd = {1'b0, m_ctrl_last[2:0]};
              if (m_ctrl_last[2:0] == CMD_EXT) m_cmd = m_cmd_sh;
              if (m_cmd == {1'b0, CMD_READ}) m_time = packed_time(it);
            end
            if (m_ctrl_last[4] && !wd[4]) begin
              m_cmd_sh = {m_ctrl_last[5], m_cmd_sh[3:1]};
              m_time = m_time >> 1;
            end
            m_ctrl_last = wd;
          end
          PORT_RTC_MODE: m_rtc_mode = wd;
          PORT_IRQ_MODE: begin
            m_irq_mode = wd;
            m_ticks = '0;
          end
          PORT_A: m_port_a = wd;
          PORT_C: m_port_c = wd;
          PORT_SYS_CTRL: begin
            if (wd[7]) m_sys_mode = wd;
            else m_port_c[wd[3:1]] = wd[0];
          end
          default: ;
        endcase
      end
      OP_TICK: begin
        if (m_irq_mode[1:0] != IRQ_OFF) begin
          m_ticks = m_ticks + 3'd1;
          if (m_ticks > {1'b0, m_irq_mode[1:0]}) begin
            m_irq = 1'b1;
            m_ticks = '0;
          end
        end
      end
      default: ;
    endcase
    r.read_data = rd;
    r.irq_level = m_irq;
    r.port_c_out = m_port_c;
    r.shutdown_flag = m_port_c[7] & m_port_c[5];
    return r;
  endfunction

  function automatic item_t rand_time();
    item_t it;
    it = '0;
    if ($urandom_range(0, 3) == 0) begin
      it.now_sec = 6'($urandom);
      it.now_min = 6'($urandom);
      it.now_hour = 5'($urandom);
      it.now_mday = 5'($urandom);
      it.now_wday = 3'($urandom);
      it.now_month = 4'($urandom);
      it.now_year = 7'($urandom);
    end else begin
      it.now_sec = 6'($urandom_range(0, 59));
      it.now_min = 6'($urandom_range(0, 59));
      it.now_hour = 5'($urandom_range(0, 23));
      it.now_mday = 5'($urandom_range(1, 31));
      it.now_wday = 3'($urandom_range(0, 6));
      it.now_month = 4'($urandom_range(0, 11));
      it.now_year = 7'($urandom_range(0, 99));
    end
    return it;
  endfunction

  task automatic send_item(input item_t it, input logic typed, input result_t res);
    result_t want;
    if (!quiet && !in_calm && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= it.op;
    in_port <= it.port;
    in_write_data <= it.write_data;
    in_now_sec <= it.now_sec;
    in_now_min <= it.now_min;
    in_now_hour <= it.now_hour;
    in_now_mday <= it.now_mday;
    in_now_wday <= it.now_wday;
    in_now_month <= it.now_month;
    in_now_year <= it.now_year;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    want = step_ports(it);
    due_q.push_back(typed ? res : want);
    n_sent++;
    if ($urandom_range(0, 79) == 0) in_calm = !in_calm;
  endtask

  task automatic put(input op_t o, input port_t p, input logic [7:0] d);
    item_t it;
    it = rand_time();
    it.op = o;
    it.port = p;
    it.write_data = d;
    send_item(it, 1'b0, R_NONE);
  endtask

  initial begin
    item_t      it;
    logic [3:0] cmd_bits;
    int         n;
    int         k;
    m_rtc_mode = 8'hff;
    m_ctrl_last = '0;
    m_cmd = '0;
    m_time = '0;
    m_cmd_sh = '0;
    m_irq_mode = 8'h02;
    m_ticks = '0;
    m_irq = 1'b0;
    m_port_a = '0;
    m_port_c = 8'hff;
    m_sys_mode = 8'h92;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_DIR; i++) begin
      it = rand_time();
      if (DIR_TAB[i].tmax) begin
        it.now_sec = '1;
        it.now_min = '1;
        it.now_hour = '1;
        it.now_mday = '1;
        it.now_wday = '1;
        it.now_month = '1;
        it.now_year = '1;
      end
      it.op = DIR_TAB[i].op;
      it.port = DIR_TAB[i].port;
      it.write_data = DIR_TAB[i].wd;
      send_item(it, DIR_TAB[i].typed, DIR_TAB[i].res);
    end

    while (n_sent < N_DIR + N_RANDOM) begin
      if (n_sent > N_DIR + N_RANDOM - 150) quiet = 1'b1;
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          if ($urandom_range(0, 3) == 0)
            put(OP_WRITE, PORT_RTC_MODE, 8'($urandom_range(0, 255)));
          if ($urandom_range(0, 3) != 0)
            put(OP_WRITE, PORT_SYS_CTRL, 8'($urandom_range(0, 255)) | 8'h82);
          cmd_bits = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                                 : {1'b0, CMD_READ};
          if ($urandom_range(0, 1) == 1) begin
            for (k = 0; k < 4; k++) begin
              put(OP_WRITE, PORT_RTC_CTRL, {2'b00, cmd_bits[k], 5'h10});
              put(OP_WRITE, PORT_RTC_CTRL, {2'b00, cmd_bits[k], 5'h00});
            end
            put(OP_WRITE, PORT_RTC_CTRL, {5'h01, CMD_EXT});
          end else begin
            put(OP_WRITE, PORT_RTC_CTRL, {5'h01, cmd_bits[2:0]});
          end
          put(OP_WRITE, PORT_RTC_CTRL, 8'h00);
          n = ($urandom_range(0, 5) == 0) ? $urandom_range(52, 56) : $urandom_range(1, 12);
          for (k = 0; k < n; k++) begin
            put(OP_WRITE, PORT_RTC_CTRL, {2'b00, 1'($urandom_range(0, 1)), 5'h10});
            put(OP_WRITE, PORT_RTC_CTRL, 8'h00);
            put(OP_READ, PORT_B, 8'($urandom_range(0, 255)));
          end
        end
        4, 5: begin
          put(OP_WRITE, PORT_IRQ_MODE, 8'($urandom_range(0, 255)));
          n = $urandom_range(1, 10);
          for (k = 0; k < n; k++) begin
            if ($urandom_range(0, 4) == 0)
              put(OP_READ, PORT_IRQ_MODE, 8'($urandom));
            else
              put(OP_TICK, port_t'($urandom_range(0, 7)), 8'($urandom));
          end
          put(OP_READ, PORT_IRQ_MODE, 8'($urandom));
        end
        6, 7: begin
          n = $urandom_range(2, 8);
          for (k = 0; k < n; k++) begin
            case ($urandom_range(0, 5))
              0: put(OP_WRITE, PORT_SYS_CTRL, 8'($urandom_range(0, 127)));
              1: put(OP_WRITE, PORT_SYS_CTRL, 8'($urandom_range(128, 255)));
              2: put(OP_WRITE, PORT_A, 8'($urandom_range(0, 255)));
              3: put(OP_WRITE, PORT_C, 8'($urandom_range(0, 255)));
              default: put(OP_READ, port_t'($urandom_range(3, 5)), 8'($urandom));
            endcase
          end
        end
        default: begin
          n = $urandom_range(1, 4);
          for (k = 0; k < n; k++)
            put(op_t'($urandom_range(0, 3)), port_t'($urandom_range(0, 7)),
                8'($urandom_range(0, 255)));
        end
      endcase
    end

    in_valid <= 1'b0;
    while (due_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (n_bad == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  always @(posedge clk) begin
    if (hold_n > 0) hold_n--;
    else if (!quiet && !out_calm && $urandom_range(0, 11) == 0) hold_n = $urandom_range(1, 14);
    if ($urandom_range(0, 199) == 0) out_calm = !out_calm;
    out_stall <= (hold_n > 0);
  end

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_read_data, out_irq_level, out_port_c_out, out_shutdown_flag};
      if (due_q.size() == 0) begin
        n_bad++;
        if (n_bad <= 10)
          $display("unexpected item: read_data %h irq %b port_c %h shutdown %b",
                   got.read_data, got.irq_level, got.port_c_out, got.shutdown_flag);
      end else begin
        want = due_q.pop_front();
        if (got.read_data !== want.read_data || got.irq_level !== want.irq_level ||
            got.port_c_out !== want.port_c_out || got.shutdown_flag !== want.shutdown_flag) begin
          n_bad++;
          if (n_bad <= 10)
            $display("mismatch: read_data %h/%h irq %b/%b port_c %h/%h shutdown %b/%b",
                     want.read_data, got.read_data, want.irq_level, got.irq_level,
                     want.port_c_out, got.port_c_out, want.shutdown_flag, got.shutdown_flag);
        end
      end
    end
  end

  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

endmodule

### sim.f
src/srsp_pkg.sv
src/srsp_time_pack.sv
src/srsp_core.sv
src/serial_rtc_system_port_top.sv
tb/serial_rtc_system_port_top_tb.sv
